// ===== hw/rtl/nns_pkg.sv =====
// Shared types and constants for the nearest normal search block.
package nns_pkg;

  localparam int IDX_W = 10;
  localparam int CFG_W = 11;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/nns_dot.sv =====
// Pipelined three-term dot product unit shared by every table entry of a query.
module nns_dot #(
  parameter int CB = 16,
  parameter int TW = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  logic [TW-1:0]        in_tag,
  input  logic signed [CB-1:0] qx,
  input  logic signed [CB-1:0] qy,
  input  logic signed [CB-1:0] qz,
  input  logic signed [CB-1:0] ex,
  input  logic signed [CB-1:0] ey,
  input  logic signed [CB-1:0] ez,
  output logic                 sum_vld,
  output logic [TW-1:0]        sum_tag,
  output logic signed [2*CB+1:0] sum,
  output logic                 busy
);

  logic                   vld1;
  logic [TW-1:0]          tag1;
  logic signed [2*CB-1:0] p0;
  logic signed [2*CB-1:0] p1;
  logic signed [2*CB-1:0] p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      sum_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      sum_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    tag1    <= in_tag;
    p0      <= qx * ex;
    p1      <= qy * ey;
    p2      <= qz * ez;
    sum_tag <= tag1;
    sum     <= (2*CB+2)'(p0) + (2*CB+2)'(p1) + (2*CB+2)'(p2);
  end

  assign busy = vld1 | sum_vld;

endmodule

// ===== hw/rtl/nearest_normal_search.sv =====
// Top level of the nearest normal search: normal table, sequencer and result register.
//
//   channel  direction  handshake            word
//   in       to block   in_valid / in_stall  func, entry_index, vec_x, vec_y, vec_z
//   out      from block out_valid / out_stall best_index
//   cfg      to block   cfg_valid / cfg_ready cfg_data (point_count)
//
// A write word leaves the sequencer idle, so the block is ready again on the next cycle.
// A query reads min(point_count, MAX_POINTS) table entries, one table read per cycle, through
// the accept, read, product, sum, compare and result stages; a zero vector or an empty search
// skips to DONE. Reset clears control state only; table entries are undefined until written.
// A stalled result is held; a query that finishes behind it waits in its final stage.
module nearest_normal_search #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [nns_pkg::IDX_W-1:0]     entry_index,
  input  logic signed [COORD_BITS-1:0]  vec_x,
  input  logic signed [COORD_BITS-1:0]  vec_y,
  input  logic signed [COORD_BITS-1:0]  vec_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nns_pkg::IDX_W-1:0]     best_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nns_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = 2 * CB + 2;
  localparam int IW = nns_pkg::IDX_W;

  nns_pkg::state_t state;
  nns_pkg::state_t state_next;

  logic [nns_pkg::CFG_W-1:0] point_count;
  logic [CW-1:0]             limit;
  logic [CW-1:0]             limit_next;
  logic [31:0]               lim32;
  logic [CW-1:0]             cnt;
  logic [CW-1:0]             cnt_inc;

  logic signed [CB-1:0] qx;
  logic signed [CB-1:0] qy;
  logic signed [CB-1:0] qz;

  logic [3*CB-1:0] mem [MAX_POINTS];
  logic [3*CB-1:0] rd_data;
  logic            rd_vld;
  logic [AW-1:0]   rd_idx;

  logic                 sum_vld;
  logic [AW-1:0]        sum_tag;
  logic signed [SW-1:0] sum;
  logic                 dot_busy;

  logic signed [SW-1:0] best_dot;
  logic [AW-1:0]        best;

  logic in_acc;
  logic wr_en;
  logic rd_issue;
  logic out_load;
  logic zero_vec;

  assign in_acc   = in_valid & ~in_stall;
  assign zero_vec = (vec_x == '0) && (vec_y == '0) && (vec_z == '0);
  assign wr_en    = in_acc && (func == nns_pkg::FUNC_WRITE) &&
                    (32'(entry_index) < 32'(MAX_POINTS));
  assign lim32    = (32'(point_count) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS)
                                                         : 32'(point_count);
  assign limit_next = lim32[CW-1:0];
  assign cnt_inc  = cnt + 1'b1;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      nns_pkg::ST_IDLE: begin
        if (in_acc && (func == nns_pkg::FUNC_QUERY)) begin
          if (zero_vec || (limit_next == '0)) begin
            state_next = nns_pkg::ST_DONE;
          end else begin
            state_next = nns_pkg::ST_RUN;
          end
        end
      end
      nns_pkg::ST_RUN: begin
        if (cnt_inc == limit) begin
          state_next = nns_pkg::ST_DRAIN;
        end
      end
      nns_pkg::ST_DRAIN: begin
        if (!rd_vld && !dot_busy) begin
          state_next = nns_pkg::ST_DONE;
        end
      end
      nns_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = nns_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nns_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = (state != nns_pkg::ST_IDLE);
    rd_issue = (state == nns_pkg::ST_RUN);
    out_load = (state == nns_pkg::ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= nns_pkg::ST_IDLE;
      point_count <= '0;
      out_valid   <= 1'b0;
      rd_vld      <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_issue;
      if (cfg_valid && cfg_ready) begin
        point_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (func == nns_pkg::FUNC_QUERY)) begin
      qx    <= vec_x;
      qy    <= vec_y;
      qz    <= vec_z;
      limit <= limit_next;
      cnt   <= '0;
    end else if (rd_issue) begin
      cnt <= cnt_inc;
    end
    if (out_load) begin
      best_index <= IW'(best);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (func == nns_pkg::FUNC_QUERY)) begin
      best <= '0;
    end else if (sum_vld && ((sum_tag == '0) || (sum > best_dot))) begin
      best     <= sum_tag;
      best_dot <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(entry_index)] <= {vec_x, vec_y, vec_z};
    end
    if (rd_issue) begin
      rd_data <= mem[cnt[AW-1:0]];
      rd_idx  <= cnt[AW-1:0];
    end
  end

  nns_dot #(
    .CB(CB),
    .TW(AW)
  ) u_dot (
    .clk    (clk),
    .rst    (rst),
    .in_vld (rd_vld),
    .in_tag (rd_idx),
    .qx     (qx),
    .qy     (qy),
    .qz     (qz),
    .ex     (rd_data[3*CB-1:2*CB]),
    .ey     (rd_data[2*CB-1:CB]),
    .ez     (rd_data[CB-1:0]),
    .sum_vld(sum_vld),
    .sum_tag(sum_tag),
    .sum    (sum),
    .busy   (dot_busy)
  );

endmodule

// ===== hw/rtl/nns_chk.sv =====
// Port-level checker for the nearest normal search and its bind to the top level.
module nns_chk #(
  parameter int MAX_POINTS = 1024
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      func,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [nns_pkg::IDX_W-1:0] best_index
);

  // A result word under stall keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(best_index))
    else $error("result word changed while stalled");

  // After a table write the block is ready again on the next cycle.
  a_write_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == nns_pkg::FUNC_WRITE) |=> !in_stall)
    else $error("block busy after a table write");

  // A query always keeps the block busy on the cycle after it is accepted.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == nns_pkg::FUNC_QUERY) |=> in_stall)
    else $error("block ready right after a query");

  // The result index always names a slot of the table.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(best_index) < 32'(MAX_POINTS)))
    else $error("result index beyond the table");

endmodule

bind nearest_normal_search nns_chk #(.MAX_POINTS(MAX_POINTS)) u_nns_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .func      (func),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .best_index(best_index)
);
